// ----- rtl/core/mfr_pkg.sv -----
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types, constants and the message target table for the frame router.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int FRAME_LIMIT = 288;
  localparam int CountW      = 9;

  localparam logic [7:0] MAGIC_V1    = 8'hFE;
  localparam logic [7:0] MAGIC_V2    = 8'hFD;
  localparam logic [7:0] SIGNED_FLAG = 8'h01;

  localparam logic [CountW-1:0] HDR_V1    = CountW'(6);
  localparam logic [CountW-1:0] HDR_V2    = CountW'(10);
  localparam logic [CountW-1:0] SIG_BYTES = CountW'(13);
  localparam logic [CountW-1:0] CRC_BYTES = CountW'(2);
  localparam logic [CountW-1:0] LIMIT     = CountW'(FRAME_LIMIT);

  // header byte positions
  localparam logic [CountW-1:0] POS_START = CountW'(0);
  localparam logic [CountW-1:0] POS_LEN   = CountW'(1);
  localparam logic [CountW-1:0] V2_INCOMP = CountW'(2);
  localparam logic [CountW-1:0] V2_SYS    = CountW'(5);
  localparam logic [CountW-1:0] V2_COMP   = CountW'(6);
  localparam logic [CountW-1:0] V2_ID0    = CountW'(7);
  localparam logic [CountW-1:0] V2_ID1    = CountW'(8);
  localparam logic [CountW-1:0] V2_ID2    = CountW'(9);
  localparam logic [CountW-1:0] V1_SYS    = CountW'(3);
  localparam logic [CountW-1:0] V1_COMP   = CountW'(4);
  localparam logic [CountW-1:0] V1_ID     = CountW'(5);

  // message ids that carry targets
  localparam logic [23:0] MSG_PARAM_REQ_READ = 24'd20;
  localparam logic [23:0] MSG_PARAM_REQ_LIST = 24'd21;
  localparam logic [23:0] MSG_PARAM_WRITE    = 24'd23;
  localparam logic [23:0] MSG_CMD_INT        = 24'd75;
  localparam logic [23:0] MSG_CMD_LONG       = 24'd76;

  localparam logic [1:0] CFG_ENABLED  = 2'd0;
  localparam logic [1:0] CFG_OWN_SYS  = 2'd1;
  localparam logic [1:0] CFG_OWN_COMP = 2'd2;

  typedef enum logic [1:0] {
    EV_ABSORB = 2'd0,
    EV_PASS   = 2'd1,
    EV_DONE   = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [CountW-1:0] byte_count;
    logic              is_v2;
    logic [7:0]        payload_length;
    logic [7:0]        incompat_flags;
    logic [7:0]        sender_sys;
    logic [7:0]        sender_comp;
    logic [23:0]       msg_id;
    logic [7:0]        tgt_sys;
    logic [7:0]        tgt_comp;
  } frame_state_t;

  typedef struct packed {
    event_kind_t       event_kind;
    logic [7:0]        pass_byte;
    logic [CountW-1:0] frame_length;
    logic              protocol_v2;
    logic [23:0]       message_id;
    logic [7:0]        source_system;
    logic [7:0]        source_component;
    logic              has_target;
    logic [7:0]        target_system;
    logic [7:0]        target_component;
    logic              deliver_local;
    logic              forward_frame;
  } report_t;

  typedef struct packed {
    logic       known;
    logic [5:0] off;
    logic [5:0] minlen;
  } slot_t;

  function automatic slot_t target_slot(input logic [23:0] id);
    slot_t s;
    s = '0;
    case (id)
      MSG_PARAM_REQ_LIST: begin s.known = 1'b1; s.off = 6'd0;  s.minlen = 6'd2;  end
      MSG_PARAM_REQ_READ: begin s.known = 1'b1; s.off = 6'd2;  s.minlen = 6'd4;  end
      MSG_PARAM_WRITE:    begin s.known = 1'b1; s.off = 6'd4;  s.minlen = 6'd6;  end
      MSG_CMD_LONG:       begin s.known = 1'b1; s.off = 6'd30; s.minlen = 6'd33; end
      MSG_CMD_INT:        begin s.known = 1'b1; s.off = 6'd32; s.minlen = 6'd34; end
      default:            s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/mfr_frame_parser.sv -----
// ----------------------------------------------------------------------------
// mfr_frame_parser
// Next frame state and per-beat report for one uplink byte.
// ----------------------------------------------------------------------------
module mfr_frame_parser
  import mfr_pkg::*;
(
  input  frame_state_t st,
  input  logic [7:0]   data_byte,
  input  logic         enabled,
  input  logic [7:0]   own_system_id,
  input  logic [7:0]   own_component_id,
  output frame_state_t st_next,
  output report_t      rpt
);

  frame_state_t      hdr_st;
  frame_state_t      pay_st;
  slot_t             slot;
  logic [CountW-1:0] idx;
  logic [CountW-1:0] cnt_next;
  logic [CountW-1:0] hdr;
  logic [CountW-1:0] pos;
  logic [CountW-1:0] need;
  logic              in_payload;
  logic              sig;
  logic              has;
  logic              sys_ok;
  logic              comp_ok;
  logic              for_me;
  logic              is_magic;

  assign idx      = st.byte_count;
  assign cnt_next = idx + CountW'(1);
  assign is_magic = (data_byte == MAGIC_V1) || (data_byte == MAGIC_V2);

  // header capture
  always_comb begin
    hdr_st = st;
    if (idx == POS_START) begin
      hdr_st                = '0;
      hdr_st.is_v2          = (data_byte == MAGIC_V2);
    end else if (idx == POS_LEN) begin
      hdr_st.payload_length = data_byte;
    end else if (st.is_v2) begin
      if (idx == V2_INCOMP)    hdr_st.incompat_flags = data_byte;
      else if (idx == V2_SYS)  hdr_st.sender_sys     = data_byte;
      else if (idx == V2_COMP) hdr_st.sender_comp    = data_byte;
      else if (idx == V2_ID0)  hdr_st.msg_id[7:0]    = data_byte;
      else if (idx == V2_ID1)  hdr_st.msg_id[15:8]   = data_byte;
      else if (idx == V2_ID2)  hdr_st.msg_id[23:16]  = data_byte;
    end else begin
      if (idx == V1_SYS)       hdr_st.sender_sys  = data_byte;
      else if (idx == V1_COMP) hdr_st.sender_comp = data_byte;
      else if (idx == V1_ID)   hdr_st.msg_id      = {16'd0, data_byte};
    end
  end

  assign slot       = target_slot(hdr_st.msg_id);
  assign hdr        = hdr_st.is_v2 ? HDR_V2 : HDR_V1;
  assign pos        = idx - hdr;
  assign in_payload = (idx >= hdr) && (pos < {1'b0, hdr_st.payload_length});
  assign sig        = hdr_st.is_v2 && (cnt_next >= CountW'(3)) &&
                      ((hdr_st.incompat_flags & SIGNED_FLAG) != 8'd0);
  assign need       = hdr + {1'b0, hdr_st.payload_length} + CRC_BYTES +
                      (sig ? SIG_BYTES : '0);

  // target capture
  always_comb begin
    pay_st = hdr_st;
    pay_st.byte_count = cnt_next;
    if (in_payload && slot.known) begin
      if (pos == CountW'(slot.off))
        pay_st.tgt_sys = data_byte;
      else if (pos == CountW'(slot.off) + CountW'(1))
        pay_st.tgt_comp = data_byte;
    end
  end

  assign has     = slot.known && (hdr_st.payload_length >= {2'b00, slot.minlen});
  assign sys_ok  = (pay_st.tgt_sys == 8'd0) || (pay_st.tgt_sys == own_system_id);
  assign comp_ok = (pay_st.tgt_comp == 8'd0) || (pay_st.tgt_comp == own_component_id);
  assign for_me  = has && sys_ok && comp_ok;

  always_comb begin
    st_next = st;
    rpt     = '0;
    if (!enabled || ((idx == POS_START) && !is_magic)) begin
      rpt.event_kind = EV_PASS;
      rpt.pass_byte  = data_byte;
    end else if (idx >= LIMIT) begin
      st_next.byte_count = '0;
      rpt.event_kind     = EV_ABSORB;
    end else if (cnt_next == CountW'(1)) begin
      st_next        = pay_st;
      rpt.event_kind = EV_ABSORB;
    end else if (need > LIMIT) begin
      st_next            = pay_st;
      st_next.byte_count = '0;
      rpt.event_kind     = EV_ABSORB;
    end else if (cnt_next < need) begin
      st_next        = pay_st;
      rpt.event_kind = EV_ABSORB;
    end else begin
      st_next              = pay_st;
      st_next.byte_count   = '0;
      rpt.event_kind       = EV_DONE;
      rpt.frame_length     = cnt_next;
      rpt.protocol_v2      = pay_st.is_v2;
      rpt.message_id       = pay_st.msg_id;
      rpt.source_system    = pay_st.sender_sys;
      rpt.source_component = pay_st.sender_comp;
      rpt.has_target       = has;
      rpt.target_system    = has ? pay_st.tgt_sys : 8'd0;
      rpt.target_component = has ? pay_st.tgt_comp : 8'd0;
      rpt.deliver_local    = for_me;
      rpt.forward_frame    = !has || (pay_st.tgt_sys == 8'd0) || !for_me;
    end
  end

endmodule

// ----- rtl/core/mavlink_frame_router_unit.sv -----
// ----------------------------------------------------------------------------
// mavlink_frame_router_unit
// Delimits v1/v2 uplink frames byte by byte, passes other bytes through and
// reports header fields, targets and the routing decision at frame end.
//
//   channel  direction  handshake              beat
//   in       sink       in_valid / in_ready    data_byte
//   out      source     out_valid / out_ready  event_kind ... forward_frame
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// one result beat per input beat, registered straight from the input byte
// a new byte is taken every cycle while no result beat is held; the parse
// state and target table lookup are combinational before the result register
// in_ready drops only while a result beat is held by out_ready low
// synchronous reset clears parse state and output valid and loads the
// config register defaults
// ----------------------------------------------------------------------------
module mavlink_frame_router_unit
  import mfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        event_kind,
  output logic [7:0]        pass_byte,
  output logic [CountW-1:0] frame_length,
  output logic              protocol_v2,
  output logic [23:0]       message_id,
  output logic [7:0]        source_system,
  output logic [7:0]        source_component,
  output logic              has_target,
  output logic [7:0]        target_system,
  output logic [7:0]        target_component,
  output logic              deliver_local,
  output logic              forward_frame
);

  logic         enabled;
  logic [7:0]   own_system_id;
  logic [7:0]   own_component_id;
  frame_state_t st;
  frame_state_t st_next;
  report_t      rpt_next;
  report_t      rpt;
  logic         accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  mfr_frame_parser u_parser (
    .st               (st),
    .data_byte        (data_byte),
    .enabled          (enabled),
    .own_system_id    (own_system_id),
    .own_component_id (own_component_id),
    .st_next          (st_next),
    .rpt              (rpt_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled          <= 1'b0;
      own_system_id    <= 8'd51;
      own_component_id <= 8'd68;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ENABLED:  enabled          <= cfg_data[0];
        CFG_OWN_SYS:  own_system_id    <= cfg_data;
        CFG_OWN_COMP: own_component_id <= cfg_data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) st <= st_next;
      if (accept) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rpt <= rpt_next;
  end

  assign event_kind       = rpt.event_kind;
  assign pass_byte        = rpt.pass_byte;
  assign frame_length     = rpt.frame_length;
  assign protocol_v2      = rpt.protocol_v2;
  assign message_id       = rpt.message_id;
  assign source_system    = rpt.source_system;
  assign source_component = rpt.source_component;
  assign has_target       = rpt.has_target;
  assign target_system    = rpt.target_system;
  assign target_component = rpt.target_component;
  assign deliver_local    = rpt.deliver_local;
  assign forward_frame    = rpt.forward_frame;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.byte_count <= CountW'(280))
    else $error("frame byte count beyond longest frame");

  a_disabled_pass: assert property (@(posedge clk) disable iff (rst)
    accept && !enabled |=> out_valid && (event_kind == EV_PASS) &&
      (pass_byte == $past(data_byte)))
    else $error("byte not passed through while disabled");

  a_fields_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind != EV_DONE) |->
      (frame_length == '0) && (message_id == 24'd0) && !has_target)
    else $error("frame fields set outside a frame end");

  a_local_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && deliver_local |-> has_target && (event_kind == EV_DONE))
    else $error("local delivery without a target");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    accept && (rpt_next.event_kind == EV_DONE) |=> st.byte_count == '0)
    else $error("byte count not cleared at frame end");

endmodule
